[rtl/core/lcbc_pkg.sv]
// Shared types, constants and command structures for the Luhn card brand checker.
`default_nettype none

package lcbc_pkg;

  localparam int unsigned CardW     = 63;
  localparam int unsigned NumDigits = 19;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned CntW      = 6;
  localparam int unsigned PrefixW   = 7;

  localparam logic [PrefixW-1:0] AmexA  = 7'd34;
  localparam logic [PrefixW-1:0] AmexB  = 7'd37;
  localparam logic [PrefixW-1:0] McLow  = 7'd51;
  localparam logic [PrefixW-1:0] McHigh = 7'd55;
  localparam logic [3:0]         VisaLead = 4'd4;

  typedef enum logic [1:0] {
    VerdictInvalid    = 2'd0,
    VerdictAmex       = 2'd1,
    VerdictMastercard = 2'd2,
    VerdictVisa       = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StScan,
    StDone
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic conv;
    logic scan;
  } dp_cmd_t;

endpackage

`default_nettype wire

[rtl/core/lcbc_datapath.sv]
// Datapath: shift-add-3 binary to decimal converter, digit scan, Luhn sum and brand decode.
`default_nettype none

module lcbc_datapath (
  input  wire logic                         clk_i,
  input  wire lcbc_pkg::dp_cmd_t            cmd_i,
  input  wire logic [lcbc_pkg::CardW-1:0]   card_number_i,
  output logic [1:0]                        verdict_o,
  output logic                              luhn_ok_o
);
  import lcbc_pkg::*;

  logic [CardW-1:0]   bin_q, bin_d;
  logic [BcdW-1:0]    bcd_q, bcd_d, bcd_adj;
  logic [3:0]         acc_q, acc_d;
  logic               dbl_q, dbl_d;
  logic [3:0]         prev_q, prev_d;
  logic [3:0]         lead_q, lead_d;
  logic [3:0]         second_q, second_d;
  logic [3:0]         digit;
  logic [4:0]         contrib;
  logic [4:0]         acc_sum;
  logic [PrefixW-1:0] prefix;
  verdict_e           verdict;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    digit = bcd_q[3:0];
    if (dbl_q) begin
      contrib = {digit, 1'b0};
      if (contrib >= 5'd10) begin
        contrib = contrib - 5'd9;
      end
    end else begin
      contrib = {1'b0, digit};
    end
    acc_sum = {1'b0, acc_q} + contrib;
    if (acc_sum >= 5'd10) begin
      acc_sum = acc_sum - 5'd10;
    end
  end

  always_comb begin
    bin_d    = bin_q;
    bcd_d    = bcd_q;
    acc_d    = acc_q;
    dbl_d    = dbl_q;
    prev_d   = prev_q;
    lead_d   = lead_q;
    second_d = second_q;
    priority if (cmd_i.load) begin
      bin_d    = card_number_i;
      bcd_d    = '0;
      acc_d    = '0;
      dbl_d    = 1'b0;
      prev_d   = '0;
      lead_d   = '0;
      second_d = '0;
    end else if (cmd_i.conv) begin
      bcd_d = {bcd_adj[BcdW-2:0], bin_q[CardW-1]};
      bin_d = {bin_q[CardW-2:0], 1'b0};
    end else if (cmd_i.scan) begin
      bcd_d  = {4'd0, bcd_q[BcdW-1:4]};
      acc_d  = acc_sum[3:0];
      dbl_d  = ~dbl_q;
      prev_d = digit;
      if (digit != 4'd0) begin
        lead_d   = digit;
        second_d = prev_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q    <= bin_d;
    bcd_q    <= bcd_d;
    acc_q    <= acc_d;
    dbl_q    <= dbl_d;
    prev_q   <= prev_d;
    lead_q   <= lead_d;
    second_q <= second_d;
  end

  always_comb begin
    prefix = {3'd0, lead_q} * 7'd10 + {3'd0, second_q};
    if (acc_q != 4'd0) begin
      verdict = VerdictInvalid;
    end else if (prefix == AmexA || prefix == AmexB) begin
      verdict = VerdictAmex;
    end else if (prefix >= McLow && prefix <= McHigh) begin
      verdict = VerdictMastercard;
    end else if (lead_q == VisaLead) begin
      verdict = VerdictVisa;
    end else begin
      verdict = VerdictInvalid;
    end
  end

  assign verdict_o = verdict;
  assign luhn_ok_o = (acc_q == 4'd0);

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) cmd_i.scan |-> bcd_q[3:0] <= 4'd9)
    else $error("Converter produced a digit above nine.");
  assert property (@(posedge clk_i) cmd_i.scan |=> acc_q <= 4'd9)
    else $error("Luhn accumulator left its modulo-ten range.");
  assert property (@(posedge clk_i) cmd_i.load |=> acc_q == 4'd0 && !dbl_q)
    else $error("Load did not clear the Luhn accumulator.");
`endif

endmodule

`default_nettype wire

[rtl/core/lcbc_ctrl.sv]
// Controller: sequences load, conversion and digit scan, and issues the result strobe.
`default_nettype none

module lcbc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  output logic                   done_o,
  output lcbc_pkg::dp_cmd_t      cmd_o
);
  import lcbc_pkg::*;

  ctrl_state_e     state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      StIdle: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.conv = 1'b1;
        if (cnt_q == CntW'(CardW - 1)) begin
          cnt_d   = '0;
          state_d = StScan;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (cnt_q == CntW'(NumDigits - 1)) begin
          cnt_d   = '0;
          state_d = StDone;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      StDone: begin
        done_o  = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("Accepted transfer did not raise busy.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy && !done_o)
    else $error("Result strobe lasted more than one cycle.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_o |-> $past(state_q == StScan))
    else $error("Result strobe without a completed digit scan.");
`endif

endmodule

`default_nettype wire

[rtl/core/luhn_card_brand_checker.sv]
// Top level of the Luhn card brand checker: controller and datapath.
//
//   Channel   Direction  Handshake                  Payload
//   command   in         start, busy                card_number_i[62:0]
//   result    out        done_o (one-cycle strobe)  verdict_o[1:0], luhn_ok_o
//
// A card number is taken when start is high and busy is low. The shift-add-3
// converter then turns it into decimal digits and the digit scan, one digit a cycle,
// forms the Luhn sum; done_o follows, and the next transfer can be taken in the
// cycle after the strobe.
// Reset clears the controller only; the datapath is loaded afresh on every transfer.
// The receiver cannot stall: done_o is shown for exactly one cycle.
`default_nettype none

module luhn_card_brand_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [lcbc_pkg::CardW-1:0]  card_number_i,
  output logic                             done_o,
  output logic [1:0]                       verdict_o,
  output logic                             luhn_ok_o
);
  import lcbc_pkg::*;

  dp_cmd_t cmd;

  lcbc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  lcbc_datapath u_datapath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .card_number_i (card_number_i),
    .verdict_o     (verdict_o),
    .luhn_ok_o     (luhn_ok_o)
  );

endmodule

`default_nettype wire
